/* rtl/core/prq_pkg.sv */
// Shared types, constants and helper functions for the priority ready queue scheduler.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package prq_pkg;

  // Sizing of the thread table and of the level bitmap
  localparam int MAX_THREADS = 32;
  localparam int NUM_LEVELS  = 64;
  localparam int TID_W       = $clog2(MAX_THREADS);
  localparam int LVL_W       = $clog2(NUM_LEVELS);
  localparam int RUN_W       = TID_W + 1;
  localparam int CNT_W       = RUN_W;

  // Running thread value that means no thread has been picked yet
  localparam logic [RUN_W-1:0] NO_THREAD = RUN_W'(MAX_THREADS);

  // Configuration port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic [APB_AW-3:0] REG_SCHED_LOCKED = '0;

  // Command codes
  typedef enum logic [1:0] {
    CMD_READY    = 2'd0,
    CMD_UNREADY  = 2'd1,
    CMD_CHPRIO   = 2'd2,
    CMD_SCHEDULE = 2'd3
  } cmd_e_t;

  // Command word
  typedef struct packed {
    logic [1:0]       cmd;
    logic [TID_W-1:0] thread_num;
    logic [LVL_W-1:0] prio;
    logic             in_interrupt;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic             accepted;
    logic [RUN_W-1:0] current_thread;
    logic             switched;
    logic [CNT_W-1:0] ready_count;
    logic             resched_pending;
    logic             queue_empty;
  } out_word_t;

  // Index of the set bit of a one-hot thread vector (zero when none is set)
  function automatic logic [TID_W-1:0] onehot_idx(input logic [MAX_THREADS-1:0] v);
    logic [TID_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < MAX_THREADS; i++) begin
      if (v[i]) begin
        idx = idx | TID_W'(i);
      end
    end
    return idx;
  endfunction

  // Lowest set bit of the level bitmap (zero when empty)
  function automatic logic [LVL_W-1:0] lowest_set(input logic [NUM_LEVELS-1:0] v);
    logic [LVL_W-1:0] idx;
    idx = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = LVL_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/prq_cfg.sv */
// APB-style configuration register file: holds the scheduler lock bit.
// Depends on prq_pkg for address and data widths.
`timescale 1ns / 1ps
`default_nettype none

module prq_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [prq_pkg::APB_AW-1:0] paddr,
  input  wire logic [prq_pkg::APB_DW-1:0] pwdata,
  output logic      [prq_pkg::APB_DW-1:0] prdata,
  output logic                            pready,
  output logic                            sched_locked
);
  import prq_pkg::*;

  logic hit;

  // Word decode; the low two address bits are ignored
  assign hit    = (paddr[APB_AW-1:2] == REG_SCHED_LOCKED);
  assign pready = 1'b1;

  // Lock register, set out of reset
  always_ff @(posedge clk) begin
    if (rst) begin
      sched_locked <= 1'b1;
    end else if (psel && penable && pwrite && hit) begin
      sched_locked <= pwdata[0];
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    if (hit) begin
      prdata[0] = sched_locked;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/prq_core.sv */
// Thread table, per-level linked FIFOs, level bitmap and selection logic.
// Each thread is a cell with its own next/prev links and head/tail flags; depends on prq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module prq_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               step,
  input  wire prq_pkg::in_word_t  item,
  input  wire logic               sched_locked,
  output prq_pkg::out_word_t      result
);
  import prq_pkg::*;

  // Thread cells
  logic [LVL_W-1:0]       thread_level      [MAX_THREADS];
  logic [LVL_W-1:0]       thread_level_next [MAX_THREADS];
  logic [TID_W-1:0]       next_link         [MAX_THREADS];
  logic [TID_W-1:0]       next_link_next    [MAX_THREADS];
  logic [TID_W-1:0]       prev_link         [MAX_THREADS];
  logic [TID_W-1:0]       prev_link_next    [MAX_THREADS];
  logic [MAX_THREADS-1:0] ready, ready_next;
  logic [MAX_THREADS-1:0] is_head, is_head_next;
  logic [MAX_THREADS-1:0] is_tail, is_tail_next;

  // Global state
  logic [NUM_LEVELS-1:0]  level_bitmap, level_bitmap_next;
  logic [CNT_W-1:0]       count_ready, count_ready_next;
  logic                   need_resched, need_resched_next;
  logic [RUN_W-1:0]       running_thread, running_thread_next;

  // Decode of the current command
  logic [TID_W-1:0]       t;
  logic [LVL_W-1:0]       lv;
  logic                   t_ready, t_head, t_tail, t_alone;
  logic [LVL_W-1:0]       t_level;
  logic [TID_W-1:0]       t_next, t_prev;
  logic                   do_enq, do_deq, do_setlvl, sched_go;
  logic [NUM_LEVELS-1:0]  bitmap_deq;
  logic                   level_busy;
  logic [MAX_THREADS-1:0] tail_match, head_match;
  logic [TID_W-1:0]       tail_sel, head_sel;
  logic [LVL_W-1:0]       first_level;
  logic                   accepted, switched;

  assign t       = item.thread_num;
  assign lv      = item.prio;
  assign t_ready = ready[t];
  assign t_head  = is_head[t];
  assign t_tail  = is_tail[t];
  assign t_level = thread_level[t];
  assign t_next  = next_link[t];
  assign t_prev  = prev_link[t];
  assign t_alone = t_head && t_tail;

  // Command decode
  always_comb begin
    do_enq    = 1'b0;
    do_deq    = 1'b0;
    do_setlvl = 1'b0;
    sched_go  = 1'b0;
    case (item.cmd)
      CMD_READY: begin
        do_enq    = !t_ready;
        do_setlvl = !t_ready;
      end
      CMD_UNREADY: begin
        do_deq = t_ready;
      end
      CMD_CHPRIO: begin
        do_setlvl = 1'b1;
        do_deq    = t_ready;
        do_enq    = t_ready;
      end
      CMD_SCHEDULE: begin
        sched_go = need_resched && !item.in_interrupt && !sched_locked;
      end
      default: begin
        sched_go = 1'b0;
      end
    endcase
  end

  // Bitmap after the unlink half of the command
  always_comb begin
    bitmap_deq = level_bitmap;
    if (do_deq && t_alone) begin
      bitmap_deq[t_level] = 1'b0;
    end
  end

  assign level_busy = bitmap_deq[lv];

  // Tail of the target level once the thread itself has been unlinked
  always_comb begin
    for (int i = 0; i < MAX_THREADS; i++) begin
      tail_match[i] = ready[i] && is_tail[i] && (thread_level[i] == lv) && (TID_W'(i) != t);
    end
  end

  assign tail_sel = (|tail_match) ? onehot_idx(tail_match) : t_prev;

  // Head of the highest-priority non-empty level
  assign first_level = lowest_set(level_bitmap);

  always_comb begin
    for (int i = 0; i < MAX_THREADS; i++) begin
      head_match[i] = ready[i] && is_head[i] && (thread_level[i] == first_level);
    end
  end

  assign head_sel = onehot_idx(head_match);

  // Per-cell next state: unlink first, then append at the tail
  always_comb begin
    for (int i = 0; i < MAX_THREADS; i++) begin
      thread_level_next[i] = thread_level[i];
      next_link_next[i]    = next_link[i];
      prev_link_next[i]    = prev_link[i];
      ready_next[i]        = ready[i];
      is_head_next[i]      = is_head[i];
      is_tail_next[i]      = is_tail[i];

      if (do_deq) begin
        if (TID_W'(i) == t) begin
          ready_next[i]   = 1'b0;
          is_head_next[i] = 1'b0;
          is_tail_next[i] = 1'b0;
        end
        if (!t_alone) begin
          // head moves on, or the predecessor skips over the thread
          if (t_head) begin
            if (TID_W'(i) == t_next) begin
              is_head_next[i] = 1'b1;
            end
          end else if (TID_W'(i) == t_prev) begin
            next_link_next[i] = t_next;
          end
          // tail moves back, or the successor points past the thread
          if (t_tail) begin
            if (TID_W'(i) == t_prev) begin
              is_tail_next[i] = 1'b1;
            end
          end else if (TID_W'(i) == t_next) begin
            prev_link_next[i] = t_prev;
          end
        end
      end

      if (do_setlvl && (TID_W'(i) == t)) begin
        thread_level_next[i] = lv;
      end

      if (do_enq) begin
        if (level_busy && (TID_W'(i) == tail_sel)) begin
          next_link_next[i] = t;
          is_tail_next[i]   = 1'b0;
        end
        if (TID_W'(i) == t) begin
          ready_next[i]     = 1'b1;
          is_tail_next[i]   = 1'b1;
          is_head_next[i]   = !level_busy;
          next_link_next[i] = t;
          prev_link_next[i] = level_busy ? tail_sel : t;
        end
      end
    end
  end

  // Bitmap, counters, selection
  always_comb begin
    level_bitmap_next   = bitmap_deq;
    count_ready_next    = count_ready;
    need_resched_next   = need_resched;
    running_thread_next = running_thread;
    accepted            = do_enq || do_deq;
    switched            = 1'b0;

    if (do_enq) begin
      level_bitmap_next[lv] = 1'b1;
    end
    if (do_enq && !do_deq) begin
      count_ready_next = count_ready + 1'b1;
    end else if (do_deq && !do_enq && (count_ready != '0)) begin
      count_ready_next = count_ready - 1'b1;
    end
    if (do_enq || do_deq) begin
      need_resched_next = 1'b1;
    end

    if (sched_go) begin
      need_resched_next = 1'b0;
      if (level_bitmap != '0) begin
        running_thread_next = {1'b0, head_sel};
        switched            = ({1'b0, head_sel} != running_thread);
        accepted            = 1'b1;
      end
    end
  end

  // Result word reflects the state after the command
  always_comb begin
    result.accepted        = accepted;
    result.current_thread  = running_thread_next;
    result.switched        = switched;
    result.ready_count     = count_ready_next;
    result.resched_pending = need_resched_next;
    result.queue_empty     = (level_bitmap_next == '0);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      ready          <= '0;
      is_head        <= '0;
      is_tail        <= '0;
      level_bitmap   <= '0;
      count_ready    <= '0;
      need_resched   <= 1'b0;
      running_thread <= NO_THREAD;
      for (int i = 0; i < MAX_THREADS; i++) begin
        thread_level[i] <= '0;
      end
    end else if (step) begin
      ready          <= ready_next;
      is_head        <= is_head_next;
      is_tail        <= is_tail_next;
      level_bitmap   <= level_bitmap_next;
      count_ready    <= count_ready_next;
      need_resched   <= need_resched_next;
      running_thread <= running_thread_next;
      for (int i = 0; i < MAX_THREADS; i++) begin
        thread_level[i] <= thread_level_next[i];
      end
    end
  end

  // Links carry no reset; they are only followed for queued threads
  always_ff @(posedge clk) begin
    if (step) begin
      for (int i = 0; i < MAX_THREADS; i++) begin
        next_link[i] <= next_link_next[i];
        prev_link[i] <= prev_link_next[i];
      end
    end
  end

  // Ready count tracks the ready cells
  a_count: assert property (@(posedge clk) disable iff (rst)
    $countones(ready) == int'(count_ready))
    else $error("ready count out of step with thread table");

  // One head per non-empty level
  a_heads: assert property (@(posedge clk) disable iff (rst)
    $countones(is_head & ready) == $countones(level_bitmap))
    else $error("head flags disagree with level bitmap");

  // One tail per non-empty level
  a_tails: assert property (@(posedge clk) disable iff (rst)
    $countones(is_tail & ready) == $countones(level_bitmap))
    else $error("tail flags disagree with level bitmap");

  // Bitmap is empty exactly when no thread is ready
  a_empty: assert property (@(posedge clk) disable iff (rst)
    (level_bitmap == '0) == (count_ready == '0))
    else $error("bitmap and ready count disagree on emptiness");

endmodule

`default_nettype wire

/* rtl/core/priority_ready_queue_scheduler_top.sv */
// Priority ready queue scheduler: word handshakes, input and result registers.
// Depends on prq_pkg, prq_cfg and prq_core.
// A command word is taken into an input register, applied to the thread table
// and its result word is captured in the result register on the same edge that
// updates the table; one command is taken every cycle as long as results are
// drained. The thread cells are updated in one pass (unlink, tail lookup and
// append). No clearing pass follows reset. sched_locked comes out of reset set,
// so schedule commands select nothing until it is cleared through the
// configuration port.
`timescale 1ns / 1ps
`default_nettype none

module priority_ready_queue_scheduler_top (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       item_valid,
  output logic                            item_ready,
  input  wire prq_pkg::in_word_t          item,
  output logic                            result_valid,
  input  wire logic                       result_ready,
  output prq_pkg::out_word_t              result,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [prq_pkg::APB_AW-1:0] paddr,
  input  wire logic [prq_pkg::APB_DW-1:0] pwdata,
  output logic      [prq_pkg::APB_DW-1:0] prdata,
  output logic                            pready
);
  import prq_pkg::*;

  logic      sched_locked;
  in_word_t  item_q;
  logic      item_q_valid;
  out_word_t result_d;
  logic      step;

  // Configuration registers
  prq_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .sched_locked (sched_locked)
  );

  // Held word moves on when the result register is free or draining
  assign step       = item_q_valid && (!result_valid || result_ready);
  assign item_ready = !item_q_valid || step;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else if (item_valid && item_ready) begin
      item_q_valid <= 1'b1;
    end else if (step) begin
      item_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      item_q <= item;
    end
  end

  // Queue state and selection
  prq_core u_core (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .item         (item_q),
    .sched_locked (sched_locked),
    .result       (result_d)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (step) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result <= result_d;
    end
  end

endmodule

`default_nettype wire
